FILE: src/rwtc_pkg.sv
// Package for the raycast wall texture column unit.
// Holds shared constants, the field types and the queue entry type.
// No dependencies.
`default_nettype none
package rwtc_pkg;
  localparam int TEX_SIZE_DEF = 64;
  localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd1080;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic        command;
    logic [11:0] column_x;
    logic        hit_side;
    logic [25:0] pos_x;
    logic [25:0] pos_y;
    logic [25:0] wall_distance;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic [11:0] span_start;
    logic [12:0] span_end;
    logic [15:0] line_height;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_FRAC, ST_DIV, ST_BASE, ST_POS
  } load_state_t;
endpackage
`default_nettype wire

FILE: src/rwtc_front.sv
// Front part: accepts items and holds them in a two entry queue.
// Depends on rwtc_pkg.
`default_nettype none
module rwtc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rwtc_pkg::item_t in_item,
  output logic                q_valid,
  input  wire logic           q_ready,
  output rwtc_pkg::item_t     q_item
);
  import rwtc_pkg::*;
  item_t entry [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item = entry[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= in_item;
  end
endmodule
`default_nettype wire

FILE: src/rwtc_back.sv
// Back part: column load sequencer with serial divider, and pixel stepper.
// Depends on rwtc_pkg.
`default_nettype none
module rwtc_back #(
  parameter int TEX_SIZE = rwtc_pkg::TEX_SIZE_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [12:0]     screen_height,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire rwtc_pkg::item_t q_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [38:0]          out_data
);
  import rwtc_pkg::*;
  localparam logic [31:0] TEX_MASK = 32'(TEX_SIZE - 1);
  localparam logic [32:0] DIVIDEND = 33'(TEX_SIZE) << 16;

  load_state_t state, state_next;
  logic active;
  logic [11:0] cur_column, cur_row;
  logic [12:0] end_row;
  logic [5:0] tex_col;
  logic [2:0] face_sel;
  logic [31:0] tex_pos, tex_step;

  item_t ld;
  logic [31:0] prod;
  logic [15:0] frac;
  logic [15:0] rem;
  logic [16:0] div_sh;
  logic [32:0] quo;
  logic [5:0] div_cnt;
  logic [31:0] base;

  logic out_free, is_step, is_load, do_step, emit, is_last;
  logic [12:0] nxt;
  logic [31:0] col_w, col_f;

  assign out_free = !out_valid || out_ready;
  assign is_step = q_valid && q_item.command == CMD_STEP && state == ST_IDLE;
  assign is_load = q_valid && q_item.command == CMD_LOAD && state == ST_IDLE;
  assign q_ready = (state == ST_IDLE) && (q_item.command == CMD_LOAD || out_free);
  assign do_step = is_step && out_free && active && ({1'b0, cur_row} < end_row);
  assign nxt = {1'b0, cur_row} + 13'd1;
  assign is_last = nxt >= end_row;
  assign emit = do_step && face_sel[2];
  assign div_sh = {rem, quo[32]};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (is_load) state_next = ST_MUL;
      ST_MUL:  state_next = ST_FRAC;
      ST_FRAC: state_next = ST_DIV;
      ST_DIV:  if (div_cnt == 6'd0) state_next = ST_BASE;
      ST_BASE: state_next = ST_POS;
      ST_POS:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    col_w = (32'(frac) * 32'(TEX_SIZE)) >> 16;
    col_f = col_w;
    if ((ld.hit_side && ld.dir_y > 0) || (!ld.hit_side && ld.dir_x < 0))
      col_f = 32'(TEX_SIZE - 1) - col_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active <= 1'b0;
      cur_column <= '0;
      cur_row <= '0;
      end_row <= '0;
      tex_col <= '0;
      face_sel <= '0;
      tex_pos <= '0;
      tex_step <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_ready) out_valid <= 1'b0;
      if (emit) begin
        out_valid <= 1'b1;
        out_data <= {is_last, face_sel[1:0],
                     6'((tex_pos >> 16) & TEX_MASK), tex_col, cur_row, cur_column};
      end
      if (do_step) begin
        tex_pos <= tex_pos + tex_step;
        cur_row <= nxt[11:0];
        if (is_last) active <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (is_load) begin
          ld <= q_item;
          active <= 1'b0;
        end
        ST_MUL: begin
          if (ld.hit_side == 1'b0)
            prod <= 32'(signed'({1'b0, ld.wall_distance})) * 32'(ld.dir_y);
          else
            prod <= 32'(signed'({1'b0, ld.wall_distance})) * 32'(ld.dir_x);
          rem <= '0;
          quo <= DIVIDEND;
          div_cnt <= 6'd33;
        end
        ST_FRAC: begin
          frac <= ld.hit_side ? 16'(({ld.pos_x[15:0], 16'd0} + prod) >> 16)
                              : 16'(({ld.pos_y[15:0], 16'd0} + prod) >> 16);
          if (ld.line_height == 16'd0) ld.line_height <= 16'd1;
        end
        ST_DIV: begin
          if (div_cnt != 6'd0) begin
            if (div_sh >= {1'b0, ld.line_height}) begin
              rem <= 16'(div_sh - {1'b0, ld.line_height});
              quo <= {quo[31:0], 1'b1};
            end else begin
              rem <= div_sh[15:0];
              quo <= {quo[31:0], 1'b0};
            end
            div_cnt <= div_cnt - 6'd1;
          end
          tex_col <= 6'(col_f);
        end
        ST_BASE: begin
          tex_step <= quo[31:0];
          base <= 32'(ld.span_start) - 32'(screen_height[12:1])
                  + 32'(ld.line_height[15:1]);
        end
        ST_POS: begin
          tex_pos <= 32'(base * tex_step);
          if (ld.hit_side == 1'b0)
            face_sel <= (ld.dir_x > 0) ? 3'd4 : ((ld.dir_x < 0) ? 3'd5 : 3'd0);
          else
            face_sel <= (ld.dir_y < 0) ? 3'd6 : ((ld.dir_y > 0) ? 3'd7 : 3'd0);
          cur_column <= ld.column_x;
          cur_row <= ld.span_start;
          end_row <= ld.span_end;
          active <= {1'b0, ld.span_start} < ld.span_end;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/raycast_wall_texture_column_unit.sv
// Raycast wall texture column unit: a load command computes the column
// texture setup; step commands emit at most one textured pixel each.
// Channels: s_axis (commands) -> two entry queue -> back part -> m_axis.
// s_axis_tuser is the command, s_axis_tdata the packed load fields;
// m_axis_tdata the pixel, with last on m_axis_tlast. cfg_we/cfg_data
// write screen_height.
// A step's pixel is registered, valid the cycle after it leaves the queue.
// Throughput: one step per cycle unless m_axis stalls; a load holds the
// back part busy for its 33 step serial TEX_SIZE / line_height divide.
// Reset clears all column state; screen_height returns to 1080.
// When m_axis stalls, steps wait in the queue and s_axis_tready drops
// once it is full.
`default_nettype none
module raycast_wall_texture_column_unit #(
  parameter int TEX_SIZE = rwtc_pkg::TEX_SIZE_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [12:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // command
  input  wire logic         s_axis_tuser,
  // column_x, hit_side, pos_x, pos_y, wall_distance, dir_x, dir_y,
  // span_start, span_end, line_height (low to high)
  input  wire logic [167:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // screen_x, screen_y, texel_column, texel_row, face (low to high), zeros
  output logic [39:0]       m_axis_tdata,
  output logic              m_axis_tlast
);
  import rwtc_pkg::*;
  logic [12:0] screen_height;
  item_t in_item, q_item;
  logic q_valid, q_ready;
  logic [38:0] out_data;

  always_ff @(posedge clk) begin
    if (rst) screen_height <= SCREEN_HEIGHT_RST;
    else if (cfg_we) screen_height <= cfg_data;
  end

  assign in_item.command       = s_axis_tuser;
  assign in_item.column_x      = s_axis_tdata[11:0];
  assign in_item.hit_side      = s_axis_tdata[12];
  assign in_item.pos_x         = s_axis_tdata[38:13];
  assign in_item.pos_y         = s_axis_tdata[64:39];
  assign in_item.wall_distance = s_axis_tdata[90:65];
  assign in_item.dir_x         = s_axis_tdata[108:91];
  assign in_item.dir_y         = s_axis_tdata[126:109];
  assign in_item.span_start    = s_axis_tdata[138:127];
  assign in_item.span_end      = s_axis_tdata[151:139];
  assign in_item.line_height   = s_axis_tdata[167:152];

  rwtc_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item,
    .q_valid, .q_ready, .q_item
  );

  rwtc_back #(.TEX_SIZE(TEX_SIZE)) u_back (
    .clk, .rst, .screen_height,
    .q_valid, .q_ready, .q_item,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data
  );

  assign m_axis_tdata = {2'b00, out_data[37:0]};
  assign m_axis_tlast = out_data[38];
endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench for raycast_wall_texture_column_unit: column loads and pixel steps,
// checked against a scoreboard that predicts every textured pixel.
// Depends on rwtc_pkg and the unit under src/.
`timescale 1ns / 1ps
module tb;
  import rwtc_pkg::*;

  localparam int TEX = 64;
  localparam logic [1:0] FACE_EAST  = 2'd0;
  localparam logic [1:0] FACE_WEST  = 2'd1;
  localparam logic [1:0] FACE_NORTH = 2'd2;
  localparam logic [1:0] FACE_SOUTH = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LOAD_SETTLE = 150;

  typedef struct {
    logic [11:0] sx;
    logic [11:0] sy;
    logic [5:0]  tcol;
    logic [5:0]  trow;
    logic [1:0]  face;
    logic        last;
  } pixel_t;

  class texel_scoreboard;
    logic [12:0] screen_h;
    bit          active;
    logic [11:0] column;
    logic [11:0] row;
    logic [12:0] end_row;
    logic [5:0]  tex_col;
    bit          face_ok;
    logic [1:0]  face;
    logic [31:0] tex_pos;
    logic [31:0] tex_step;
    pixel_t      pending[$];
    int          errors;
    int          pixels;
    int          loads;
    int          steps;

    function void clear();
      screen_h = SCREEN_HEIGHT_RST;
      active = 0; column = 0; row = 0; end_row = 0; tex_col = 0;
      face_ok = 0; face = 0; tex_pos = 0; tex_step = 0;
      errors = 0; pixels = 0; loads = 0; steps = 0;
    endfunction

    function void load_column(item_t it);
      logic [63:0] hit;
      logic [63:0] dist64;
      logic [63:0] dir64;
      logic [63:0] base64;
      logic [5:0]  col;
      logic [16:0] lh;
      logic signed [31:0] base;
      bit dx_pos, dx_neg, dy_pos, dy_neg;
      dx_neg = it.dir_x[17];
      dx_pos = !dx_neg && it.dir_x != 0;
      dy_neg = it.dir_y[17];
      dy_pos = !dy_neg && it.dir_y != 0;
      dist64 = {38'd0, it.wall_distance};
      if (it.hit_side == 1'b0) begin
        dir64 = {{46{it.dir_y[17]}}, it.dir_y};
        hit = {22'd0, it.pos_y, 16'd0} + dist64 * dir64;
      end else begin
        dir64 = {{46{it.dir_x[17]}}, it.dir_x};
        hit = {22'd0, it.pos_x, 16'd0} + dist64 * dir64;
      end
      col = hit[31:26];
      if ((it.hit_side && dy_pos) || (!it.hit_side && dx_neg))
        col = 6'(TEX - 1) - col;
      if (it.hit_side == 1'b0) begin
        face_ok = dx_pos || dx_neg;
        face = dx_pos ? FACE_EAST : FACE_WEST;
      end else begin
        face_ok = dy_pos || dy_neg;
        face = dy_neg ? FACE_NORTH : FACE_SOUTH;
      end
      lh = (it.line_height == 0) ? 17'd1 : {1'b0, it.line_height};
      tex_step = 32'((64'(TEX) << 16) / lh);
      base = $signed({20'd0, it.span_start}) - $signed({19'd0, screen_h >> 1})
             + $signed({15'd0, lh >> 1});
      base64 = {32'd0, base};
      tex_pos = 32'(base64 * {32'd0, tex_step});
      tex_col = col;
      column = it.column_x;
      row = it.span_start;
      end_row = it.span_end;
      active = {1'b0, it.span_start} < it.span_end;
    endfunction

    function void note_input(item_t it);
      logic [12:0] nxt;
      bit is_last;
      pixel_t px;
      if (it.command == CMD_LOAD) begin
        loads++;
        load_column(it);
        return;
      end
      steps++;
      if (!active || {1'b0, row} >= end_row) return;
      nxt = {1'b0, row} + 13'd1;
      is_last = nxt >= end_row;
      if (face_ok) begin
        px.sx = column; px.sy = row; px.tcol = tex_col;
        px.trow = tex_pos[21:16] & 6'(TEX - 1);
        px.face = face; px.last = is_last;
        pending.push_back(px);
      end
      tex_pos += tex_step;
      row = nxt[11:0];
      if (is_last) active = 0;
    endfunction

    function void check_result(logic [39:0] data, logic tlast);
      pixel_t e;
      pixels++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pixel data=%h last=%b", $time, data, tlast);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[11:0] !== e.sx) begin
        $display("%0t: screen_x exp %0d got %0d", $time, e.sx, data[11:0]); errors++;
      end
      if (data[23:12] !== e.sy) begin
        $display("%0t: screen_y exp %0d got %0d", $time, e.sy, data[23:12]); errors++;
      end
      if (data[29:24] !== e.tcol) begin
        $display("%0t: texel_column exp %0d got %0d", $time, e.tcol, data[29:24]);
        errors++;
      end
      if (data[35:30] !== e.trow) begin
        $display("%0t: texel_row exp %0d got %0d", $time, e.trow, data[35:30]);
        errors++;
      end
      if (data[37:36] !== e.face) begin
        $display("%0t: face exp %0d got %0d", $time, e.face, data[37:36]); errors++;
      end
      if (tlast !== e.last) begin
        $display("%0t: last exp %0b got %0b", $time, e.last, tlast); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [12:0] cfg_data = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic s_axis_tuser = 0;
  logic [167:0] s_axis_tdata = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tlast;

  texel_scoreboard sb;
  bit send_gaps = 1;
  bit recv_gaps = 1;
  bit long_hold = 0;
  int cycles = 0;
  int sent = 0;
  int stall_left = 0;

  raycast_wall_texture_column_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.clear();
  end

  // receiver: check, then pick the next stall
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end else if (long_hold) begin
        long_hold = 0;
        stall_left = 400;
      end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  function automatic logic [167:0] pack_item(item_t it);
    return {it.line_height, it.span_end, it.span_start, it.dir_y, it.dir_x,
            it.wall_distance, it.pos_y, it.pos_x, it.hit_side, it.column_x};
  endfunction

  task automatic send_item(item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.command;
    s_axis_tdata <= pack_item(it);
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(it);
    sent++;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic write_height(logic [12:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.screen_h = v;
  endtask

  function automatic item_t step_cmd();
    item_t it;
    it = '0;
    it.command = CMD_STEP;
    it.column_x = 12'($urandom);
    it.pos_x = 26'($urandom);
    return it;
  endfunction

  function automatic item_t rand_load(int span_len);
    item_t it;
    it.command = CMD_LOAD;
    it.column_x = 12'($urandom);
    it.hit_side = 1'($urandom);
    it.pos_x = 26'($urandom);
    it.pos_y = 26'($urandom);
    it.wall_distance = ($urandom_range(0, 3) == 0) ? 26'($urandom) : 26'($urandom_range(0, 1 << 20));
    it.dir_x = 18'($urandom);
    it.dir_y = 18'($urandom);
    if ($urandom_range(0, 9) == 0) it.dir_x = 0;
    if ($urandom_range(0, 9) == 0) it.dir_y = 0;
    case ($urandom_range(0, 3))
      0: it.line_height = 16'($urandom);
      1: it.line_height = 16'($urandom_range(0, 4));
      default: it.line_height = 16'($urandom_range(1, 2000));
    endcase
    it.span_start = 12'($urandom_range(0, 4095 - span_len));
    it.span_end = 13'(it.span_start) + 13'(span_len);
    return it;
  endfunction

  task automatic run_column(item_t ld, int n);
    send_item(ld);
    repeat (n) send_item(step_cmd());
  endtask

  initial begin
    item_t it;
    int len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: steps with no column, extreme fields, every face, special spans
    send_item(step_cmd());
    it = rand_load(3);
    it.pos_x = '1; it.pos_y = '1; it.wall_distance = '1; it.column_x = '1;
    it.dir_x = 18'sh1FFFF; it.dir_y = 18'sh20000; it.hit_side = 0; it.line_height = 0;
    run_column(it, 4);
    it = rand_load(2);
    it.pos_x = 0; it.pos_y = 0; it.wall_distance = 0; it.column_x = 0;
    it.dir_x = 18'sh20000; it.dir_y = 18'sh1FFFF; it.hit_side = 0; it.line_height = '1;
    run_column(it, 2);
    it = rand_load(2); it.hit_side = 1; it.dir_y = -18'sd5; run_column(it, 2);
    it = rand_load(2); it.hit_side = 1; it.dir_y = 18'sd7; run_column(it, 2);
    it = rand_load(2); it.hit_side = 1; it.dir_y = 0; run_column(it, 3);
    it = rand_load(2); it.hit_side = 0; it.dir_x = 0; run_column(it, 2);
    it = rand_load(1); it.span_start = 12'd4095; it.span_end = 13'd4096; run_column(it, 2);
    it = rand_load(0); it.span_start = 12'd100; it.span_end = 13'd40; run_column(it, 1);

    write_height(13'd0);
    run_column(rand_load(5), 5);
    write_height(13'd4096);
    run_column(rand_load(5), 5);
    write_height(13'd1);
    run_column(rand_load(5), 5);
    write_height(SCREEN_HEIGHT_RST);

    // receiver stops for a long stretch while a long column queues up
    long_hold = 1;
    it = rand_load(60); it.dir_x = 18'sd100; it.dir_y = 18'sd100; it.hit_side = 0;
    run_column(it, 60);
    drain();

    while (sent < 1150) begin
      if (sent > 1000) begin
        send_gaps = 0;
        recv_gaps = 0;
      end
      if (sent % 300 < 25 && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: write_height(13'd0);
          1: write_height(13'd4096);
          default: write_height(13'($urandom_range(1, 4096)));
        endcase
      end
      if ($urandom_range(0, 6) != 0) begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
        run_column(rand_load(len), len + $urandom_range(0, 2));
      end else if ($urandom_range(0, 1) == 0) begin
        send_item(step_cmd());
      end else begin
        it = rand_load(1);
        it.span_start = 12'($urandom);
        it.span_end = 13'($urandom_range(0, 4096));
        run_column(it, $urandom_range(0, 6));
      end
    end
    drain();

    $display("Sent %0d transactions: %0d loads, %0d steps; %0d pixels checked.",
             sent, sb.loads, sb.steps, sb.pixels);
    $display("Covered all faces, no-face and empty spans, height extremes and long stalls.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
